[src/assert_macros.svh]
// assertion macros shared by the codon log-probability marginalizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CLPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property that must hold in the cycle after a trigger
`define CLPM_ASSERT_NEXT(label, trig, prop, msg) \
   `CLPM_ASSERT(label, (trig) |=> (prop), msg)

`endif

[src/clpm_pkg.sv]
// package: constants, types, microcode words and correction table build
package clpm_pkg;

   localparam int ALPHABET_SIZE = 4;
   localparam int CORRECTION_TABLE_ENTRIES = 256;
   localparam int BASE_CODE_W = 3;
   localparam int VALUE_W = 32;
   localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int BASE_W = $clog2(ALPHABET_SIZE);
   localparam int CORR_IDX_W = $clog2(CORRECTION_TABLE_ENTRIES);
   localparam int SPAN_W = 20;
   localparam int CORR_PROD_W = SPAN_W + CORR_IDX_W;
   localparam int CORR_W = 16;

   localparam logic [VALUE_W-1:0] LOG_ZERO = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] CORR_SPAN = 32'h0010_0000;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef logic [BASE_W-1:0] base_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CORR_W-1:0] corr_table_type [CORRECTION_TABLE_ENTRIES];

   // microcode steps
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_READ,
      STEP_LOG1,
      STEP_LOG2,
      STEP_RESPOND
   } step_type;

   // how the sequencer picks its next step
   typedef enum logic [1:0] {
      BR_NEXT,
      BR_LOOKUP,
      BR_MORE,
      BR_OUT_FREE
   } branch_type;

   typedef struct packed {
      logic       req_ready;
      logic       rd_en;
      logic       stage1;
      logic       stage2;
      logic       respond;
      branch_type br;
      step_type   target;
   } ctl_word_type;

   typedef struct packed {
      logic lookup_accept;
      logic more;
      logic out_free;
   } stat_type;

   function automatic addr_type codon_addr(input base_type a, input base_type b,
                                          input base_type c);
      return ADDR_W'((int'(a) * ALPHABET_SIZE + int'(b)) * ALPHABET_SIZE + int'(c));
   endfunction

   // restoring long division, evaluated only while building the constant table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ln(1 + exp(-x)) in q16 at the left edge of correction bin idx
   function automatic logic [CORR_W-1:0] corr_entry(input int idx);
      logic [63:0] x32, k, r, e, t, y, y30, z, z2, p, s, q;
      x32 = udiv64(64'(idx) << 20, 64'(CORRECTION_TABLE_ENTRIES)) << 16;
      k = udiv64(x32, LN2_Q32);
      r = x32 - k * LN2_Q32;
      e = 64'd1 << 32;
      t = 64'd1 << 32;
      for (int n = 1; n <= 16; n++) begin
         t = udiv64((t * r) >> 32, 64'(n));
         if (n % 2 == 1) begin
            e = e - t;
         end else begin
            e = e + t;
         end
      end
      if (k > 64'd40) begin
         k = 64'd40;
      end
      y = e >> k;
      y30 = y >> 2;
      z = udiv64(y30 << 30, (64'd1 << 31) + y30);
      z2 = (z * z) >> 30;
      p = z;
      s = '0;
      for (int n = 1; n <= 21; n += 2) begin
         s = s + udiv64(p, 64'(n));
         p = (p * z2) >> 30;
      end
      q = (2 * s + (64'd1 << 13)) >> 14;
      return q[CORR_W-1:0];
   endfunction

   function automatic corr_table_type build_corr_table();
      corr_table_type tab;
      for (int i = 0; i < CORRECTION_TABLE_ENTRIES; i++) begin
         tab[i] = corr_entry(i);
      end
      return tab;
   endfunction

   localparam corr_table_type CORR_TABLE = build_corr_table();

endpackage

[src/clpm_seq.sv]
// microcode sequencer: step counter, control rom and branch logic
`include "assert_macros.svh"

module clpm_seq
   import clpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  stat_type     stat,
   output ctl_word_type ctl
);

   step_type pc_ff, pc_in;

   // control rom
   always_comb begin
      ctl = '{req_ready: 1'b0, rd_en: 1'b0, stage1: 1'b0, stage2: 1'b0,
              respond: 1'b0, br: BR_NEXT, target: STEP_IDLE};
      unique case (pc_ff)
         STEP_IDLE: begin
            ctl.req_ready = 1'b1;
            ctl.br = BR_LOOKUP;
            ctl.target = STEP_IDLE;
         end
         STEP_READ: begin
            ctl.rd_en = 1'b1;
         end
         STEP_LOG1: begin
            ctl.stage1 = 1'b1;
            ctl.rd_en = 1'b1;
         end
         STEP_LOG2: begin
            ctl.stage2 = 1'b1;
            ctl.br = BR_MORE;
            ctl.target = STEP_LOG1;
         end
         STEP_RESPOND: begin
            ctl.respond = 1'b1;
            ctl.br = BR_OUT_FREE;
            ctl.target = STEP_IDLE;
         end
         default: begin
            ctl.br = BR_OUT_FREE;
            ctl.target = STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      unique case (ctl.br)
         BR_NEXT: pc_in = step_type'(pc_ff + 3'd1);
         BR_LOOKUP: pc_in = stat.lookup_accept ? step_type'(pc_ff + 3'd1) : ctl.target;
         BR_MORE: pc_in = stat.more ? ctl.target : step_type'(pc_ff + 3'd1);
         BR_OUT_FREE: pc_in = stat.out_free ? ctl.target : pc_ff;
         default: pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `CLPM_ASSERT(a_seq_log_order, (pc_ff == STEP_LOG1) |=> (pc_ff == STEP_LOG2), "log-add steps out of order")
   `CLPM_ASSERT_NEXT(a_seq_lookup_start, stat.lookup_accept, pc_ff == STEP_READ, "lookup did not start reading")
   `CLPM_ASSERT(a_seq_accept_idle, stat.lookup_accept |-> (pc_ff == STEP_IDLE), "lookup taken while busy")

endmodule

[src/clpm_datapath.sv]
// datapath: codon memory, base counters, two-step log-add and result register
`include "assert_macros.svh"

module clpm_datapath
   import clpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_word_type             ctl,
   output stat_type                 stat,
   input  logic                     req_valid,
   input  logic                     req_operation,
   input  logic [BASE_CODE_W-1:0]   req_first_base,
   input  logic [BASE_CODE_W-1:0]   req_second_base,
   input  logic [BASE_CODE_W-1:0]   req_third_base,
   input  logic [VALUE_W-1:0]       req_entry_log_prob,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [VALUE_W-1:0]       rsp_result_log_prob
);

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];

   logic [BASE_CODE_W-1:0] req_base [3];
   logic                   req_wild [3];
   logic                   req_accept;
   logic                   concrete;
   logic                   mem_we;
   logic                   rd_issue;

   base_type cnt_ff [3];
   base_type cnt_in [3];
   base_type cnt_next [3];
   logic     wild_ff [3];
   logic     wild_in [3];
   logic     carry;
   logic     last;
   logic     done_ff, done_in;
   logic     rd_fresh_ff, rd_fresh_in;
   logic [VALUE_W-1:0] rd_data_ff;

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] hi_ff, hi_in;
   logic               corr_en_ff, corr_en_in;
   logic [CORR_IDX_W-1:0] idx_ff, idx_in;

   logic [VALUE_W-1:0] op_a, op_b, op_hi, op_lo, diff;
   logic               a_lz, b_lz;
   logic [CORR_PROD_W-1:0] prod;
   logic [CORR_W-1:0]  corr;
   logic [VALUE_W:0]   sum;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic               out_free;

   assign req_base[0] = req_first_base;
   assign req_base[1] = req_second_base;
   assign req_base[2] = req_third_base;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_wild[i] = int'(req_base[i]) >= ALPHABET_SIZE;
      end
   end

   assign req_accept = req_valid && ctl.req_ready;
   assign concrete = !req_wild[0] && !req_wild[1] && !req_wild[2];
   assign mem_we = req_accept && (req_operation == OP_WRITE) && concrete;
   assign rd_issue = ctl.rd_en && !done_ff;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[codon_addr(req_base[0][BASE_W-1:0], req_base[1][BASE_W-1:0],
                        req_base[2][BASE_W-1:0])] <= req_entry_log_prob;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[codon_addr(cnt_ff[0], cnt_ff[1], cnt_ff[2])];
      end
   end

   // odometer over the wildcard positions, third base fastest
   always_comb begin
      carry = 1'b1;
      for (int i = 2; i >= 0; i--) begin
         cnt_next[i] = cnt_ff[i];
         if (carry && wild_ff[i]) begin
            if (cnt_ff[i] == BASE_W'(ALPHABET_SIZE - 1)) begin
               cnt_next[i] = '0;
            end else begin
               cnt_next[i] = cnt_ff[i] + 1'b1;
               carry = 1'b0;
            end
         end
      end
      last = carry;
   end

   always_comb begin
      done_in = done_ff;
      rd_fresh_in = rd_fresh_ff;
      for (int i = 0; i < 3; i++) begin
         cnt_in[i] = cnt_ff[i];
         wild_in[i] = wild_ff[i];
      end
      if (req_accept && req_operation == OP_LOOKUP) begin
         done_in = 1'b0;
         for (int i = 0; i < 3; i++) begin
            wild_in[i] = req_wild[i];
            cnt_in[i] = req_wild[i] ? '0 : req_base[i][BASE_W-1:0];
         end
      end else begin
         if (ctl.stage1) begin
            rd_fresh_in = 1'b0;
         end
         if (rd_issue) begin
            rd_fresh_in = 1'b1;
            done_in = last;
            for (int i = 0; i < 3; i++) begin
               cnt_in[i] = cnt_next[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b1;
         rd_fresh_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         rd_fresh_ff <= rd_fresh_in;
      end
      for (int i = 0; i < 3; i++) begin
         cnt_ff[i] <= cnt_in[i];
         wild_ff[i] <= wild_in[i];
      end
   end

   // log-add first step: max, difference, correction bin
   always_comb begin
      a_lz = acc_ff == LOG_ZERO;
      b_lz = rd_data_ff == LOG_ZERO;
      op_a = acc_ff ^ SIGN_FLIP;
      op_b = rd_data_ff ^ SIGN_FLIP;
      op_hi = (op_a > op_b) ? op_a : op_b;
      op_lo = (op_a > op_b) ? op_b : op_a;
      diff = op_hi - op_lo;
      prod = CORR_PROD_W'(diff[SPAN_W-1:0]) * CORR_PROD_W'(CORRECTION_TABLE_ENTRIES);
      idx_in = prod[SPAN_W +: CORR_IDX_W];
      corr_en_in = !a_lz && !b_lz && (diff < CORR_SPAN);
      if (a_lz) begin
         hi_in = op_b;
      end else if (b_lz) begin
         hi_in = op_a;
      end else begin
         hi_in = op_hi;
      end
   end

   // log-add second step: add correction, saturate
   always_comb begin
      corr = corr_en_ff ? CORR_TABLE[idx_ff] : '0;
      sum = {1'b0, hi_ff} + {{(VALUE_W + 1 - CORR_W){1'b0}}, corr};
      acc_in = acc_ff;
      if (req_accept && req_operation == OP_LOOKUP) begin
         acc_in = LOG_ZERO;
      end else if (ctl.stage2) begin
         acc_in = (sum[VALUE_W] ? '1 : sum[VALUE_W-1:0]) ^ SIGN_FLIP;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.stage1) begin
         hi_ff <= hi_in;
         corr_en_ff <= corr_en_in;
         idx_ff <= idx_in;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.respond && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.respond && out_free) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_log_prob = rsp_data_ff;

   assign stat.lookup_accept = req_accept && (req_operation == OP_LOOKUP);
   assign stat.more = rd_fresh_ff;
   assign stat.out_free = out_free;

   `CLPM_ASSERT(a_dp_fresh_data, ctl.stage1 |-> rd_fresh_ff, "log-add on stale read data")
   `CLPM_ASSERT_NEXT(a_dp_no_extra_read, ctl.stage1 && done_ff, !rd_fresh_ff, "read past last entry")
   `CLPM_ASSERT(a_dp_rsp_source, $rose(rsp_valid_ff) |-> $past(ctl.respond), "result without respond step")

endmodule

[src/codon_log_prob_marginalizer.sv]
// top level of the codon log-probability marginalizer
//
// A write word (operation 0) with three concrete bases stores its Q15.16
// log-probability in the 64-entry codon memory in the cycle it is taken and
// gives no result; a write that names a wildcard base is dropped. A lookup
// word (operation 1) walks every stored codon that matches its bases (any
// base code of 4 or more matches all four bases), first base outermost and
// third base innermost, and log-sum-adds them from log-zero into one result
// word. A lookup matches 1, 4, 16 or 64 entries; each entry passes through
// the accumulator loop of the log-add (compare and subtract, then
// correction-table add with saturation), with the next memory read
// overlapped. A write leaves the sequencer in its idle step. The result
// sits in an output register, so the next word is taken while an earlier
// result still waits on rsp_ready. Entries never written since reset must
// not be looked up; their value is undefined. Control is a five-step
// microcode program driving the datapath.
`include "assert_macros.svh"

module codon_log_prob_marginalizer
   import clpm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [BASE_CODE_W-1:0]    req_first_base,
   input  logic [BASE_CODE_W-1:0]    req_second_base,
   input  logic [BASE_CODE_W-1:0]    req_third_base,
   input  logic signed [VALUE_W-1:0] req_entry_log_prob,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_result_log_prob
);

   ctl_word_type       ctl;
   stat_type           stat;
   logic [VALUE_W-1:0] result_bits;

   // step counter and control rom
   clpm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // memory, base walk, log-add and output register
   clpm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_valid           (req_valid),
      .req_operation       (req_operation),
      .req_first_base      (req_first_base),
      .req_second_base     (req_second_base),
      .req_third_base      (req_third_base),
      .req_entry_log_prob  ($unsigned(req_entry_log_prob)),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_log_prob (result_bits)
   );

   // ready only in the idle step, independent of the output register
   assign req_ready = ctl.req_ready;
   assign rsp_result_log_prob = $signed(result_bits);

   `CLPM_ASSERT(a_top_busy_no_ready,
      (rsp_valid && !rsp_ready && !req_ready) |=> !stat.lookup_accept,
      "lookup taken while busy")
   `CLPM_ASSERT_NEXT(a_top_lookup_busy,
      req_valid && req_ready && req_operation == OP_LOOKUP, !req_ready,
      "ready during lookup")
   `CLPM_ASSERT(a_top_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid,
      "result dropped before taken")

endmodule

[tb/sv/codon_sum_checker.sv]
// checker: mirrors the codon table, predicts lookup sums and compares result words
module codon_sum_checker
   import clpm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_operation,
   input  logic [BASE_CODE_W-1:0]    req_first_base,
   input  logic [BASE_CODE_W-1:0]    req_second_base,
   input  logic [BASE_CODE_W-1:0]    req_third_base,
   input  logic signed [VALUE_W-1:0] req_entry_log_prob,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_result_log_prob,
   output int unsigned               fails,
   output int unsigned               pending
);

   localparam int SHOWN_MAX = 40;

   logic [VALUE_W-1:0] codon_mirror [TABLE_DEPTH];
   logic [CORR_W-1:0]  softplus_q16 [CORRECTION_TABLE_ENTRIES];
   logic [VALUE_W-1:0] expected_sums [$];
   logic [VALUE_W-1:0] want;
   int unsigned        results_seen;

   // ln(1 + exp(-x)) in q16 at the left edge of one correction slot
   function automatic logic [CORR_W-1:0] softplus_slot(input int unsigned slot);
      logic [63:0] x32, k, r, e, t, y, y30, z, z2, p, s, q;
      x32 = ((64'(slot) << 20) / 64'(CORRECTION_TABLE_ENTRIES)) << 16;
      k = x32 / LN2_Q32;
      r = x32 - k * LN2_Q32;
      e = 64'd1 << 32;
      t = 64'd1 << 32;
      for (int n = 1; n <= 16; n++) begin
         t = ((t * r) >> 32) / 64'(n);
         if (n % 2 == 1) begin
            e = e - t;
         end else begin
            e = e + t;
         end
      end
      if (k > 64'd40) begin
         k = 64'd40;
      end
      y = e >> k;
      y30 = y >> 2;
      z = (y30 << 30) / ((64'd1 << 31) + y30);
      z2 = (z * z) >> 30;
      p = z;
      s = '0;
      for (int n = 1; n <= 21; n += 2) begin
         s = s + p / 64'(n);
         p = (p * z2) >> 30;
      end
      q = (2 * s + (64'd1 << 13)) >> 14;
      return q[CORR_W-1:0];
   endfunction

   // log-add of two q15.16 values, log-zero is the identity
   function automatic logic [VALUE_W-1:0] log_sum(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      logic [VALUE_W-1:0] fa, fb, hi, lo, d;
      logic [VALUE_W:0]   total;
      logic [CORR_W-1:0]  corr;
      if (a == LOG_ZERO) begin
         return b;
      end
      if (b == LOG_ZERO) begin
         return a;
      end
      fa = a ^ SIGN_FLIP;
      fb = b ^ SIGN_FLIP;
      hi = (fa > fb) ? fa : fb;
      lo = (fa > fb) ? fb : fa;
      d = hi - lo;
      corr = '0;
      if (d < CORR_SPAN) begin
         corr = softplus_q16[int'((64'(d) * CORRECTION_TABLE_ENTRIES) >> 20)];
      end
      total = {1'b0, hi} + (VALUE_W+1)'(corr);
      if (total[VALUE_W]) begin
         total = {1'b0, {VALUE_W{1'b1}}};
      end
      return total[VALUE_W-1:0] ^ SIGN_FLIP;
   endfunction

   // nested walk over every matching codon, first base outermost
   function automatic logic [VALUE_W-1:0] marginal_sum(input logic [BASE_CODE_W-1:0] b0,
                                                       input logic [BASE_CODE_W-1:0] b1,
                                                       input logic [BASE_CODE_W-1:0] b2);
      logic [BASE_CODE_W-1:0] code [3];
      int                     lo [3];
      int                     hi [3];
      logic [VALUE_W-1:0]     acc;
      code[0] = b0;
      code[1] = b1;
      code[2] = b2;
      for (int i = 0; i < 3; i++) begin
         if (code[i] >= ALPHABET_SIZE) begin
            lo[i] = 0;
            hi[i] = ALPHABET_SIZE - 1;
         end else begin
            lo[i] = int'(code[i]);
            hi[i] = int'(code[i]);
         end
      end
      acc = LOG_ZERO;
      for (int a = lo[0]; a <= hi[0]; a++) begin
         for (int b = lo[1]; b <= hi[1]; b++) begin
            for (int c = lo[2]; c <= hi[2]; c++) begin
               acc = log_sum(acc, codon_mirror[(a * ALPHABET_SIZE + b) * ALPHABET_SIZE + c]);
            end
         end
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string what);
      if (fails < SHOWN_MAX) begin
         $display("mismatch: %s", what);
      end
      fails++;
   endtask

   initial begin
      fails = 0;
      pending = 0;
      results_seen = 0;
      for (int i = 0; i < CORRECTION_TABLE_ENTRIES; i++) begin
         softplus_q16[i] = softplus_slot(i);
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         codon_mirror[i] = '0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         // results first: a result never belongs to a lookup taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               report_mismatch($sformatf("result word %h with no lookup pending",
                                         rsp_result_log_prob));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_result_log_prob !== want) begin
                  report_mismatch($sformatf("result %0d: result_log_prob %h, expected %h",
                                            results_seen, rsp_result_log_prob, want));
               end
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            if (req_operation == OP_LOOKUP) begin
               expected_sums.push_back(marginal_sum(req_first_base, req_second_base,
                                                    req_third_base));
            end else if (req_first_base < ALPHABET_SIZE && req_second_base < ALPHABET_SIZE
                         && req_third_base < ALPHABET_SIZE) begin
               codon_mirror[(int'(req_first_base) * ALPHABET_SIZE + int'(req_second_base))
                            * ALPHABET_SIZE + int'(req_third_base)] = req_entry_log_prob;
            end
         end
         pending = expected_sums.size();
      end
   end

endmodule

[tb/sv/tb_codon_log_prob_marginalizer.sv]
// testbench top: stimulus, idling, watchdog and verdict for the codon marginalizer
module tb_codon_log_prob_marginalizer;
   import clpm_pkg::*;

   localparam int QUIET_LIMIT = 4000;     // cycles with no word moving on either channel
   localparam int ITEMS_PER_PHASE = 500;
   localparam int SETTLE_CYCLES = 150;    // a bit more than a fully open lookup
   localparam logic [BASE_CODE_W-1:0] ANY_BASE = BASE_CODE_W'(ALPHABET_SIZE);
   localparam logic [BASE_CODE_W-1:0] ANY_BASE_TOP = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_operation;
   logic [BASE_CODE_W-1:0]    req_first_base;
   logic [BASE_CODE_W-1:0]    req_second_base;
   logic [BASE_CODE_W-1:0]    req_third_base;
   logic signed [VALUE_W-1:0] req_entry_log_prob;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_result_log_prob;

   int unsigned fails;
   int unsigned pending;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned quiet_cycles;

   // which codons the stimulus has written, so no lookup touches an unwritten one
   bit          written [TABLE_DEPTH];
   int unsigned table_writes;
   int unsigned dropped_writes;
   int unsigned lookups;
   int unsigned open_lookups;

   codon_log_prob_marginalizer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_first_base      (req_first_base),
      .req_second_base     (req_second_base),
      .req_third_base      (req_third_base),
      .req_entry_log_prob  (req_entry_log_prob),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_log_prob (rsp_result_log_prob)
   );

   codon_sum_checker sum_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_first_base      (req_first_base),
      .req_second_base     (req_second_base),
      .req_third_base      (req_third_base),
      .req_entry_log_prob  (req_entry_log_prob),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_log_prob (rsp_result_log_prob),
      .fails               (fails),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver side: back-pressure drawn fresh every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("** codon_log_prob_marginalizer: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // log-probability mix: log-zero, extremes, close values that hit the
   // correction table, values near the top that saturate, and raw bits
   function automatic logic [VALUE_W-1:0] pick_log_prob();
      case ($urandom_range(0, 19)) inside
         [0:1]:   return LOG_ZERO;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0001;
         [4:12]:  return -VALUE_W'($urandom_range(0, 24 * 65536));
         [13:15]: return 32'h7FF0_0000 + VALUE_W'($urandom_range(0, 32'h000F_FFFF));
         default: return $urandom;
      endcase
   endfunction

   // true when every codon matched by the pattern is written, else the first hole
   function automatic bit covered(input logic [BASE_CODE_W-1:0] code [3], output int hole);
      int idx;
      hole = -1;
      for (int a = 0; a < ALPHABET_SIZE; a++) begin
         for (int b = 0; b < ALPHABET_SIZE; b++) begin
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
               idx = (a * ALPHABET_SIZE + b) * ALPHABET_SIZE + c;
               if ((code[0] >= ALPHABET_SIZE || code[0] == a)
                   && (code[1] >= ALPHABET_SIZE || code[1] == b)
                   && (code[2] >= ALPHABET_SIZE || code[2] == c)
                   && !written[idx] && hole < 0) begin
                  hole = idx;
               end
            end
         end
      end
      return hole < 0;
   endfunction

   // one word on the request channel; valid only ever changes at a falling edge
   task automatic send_word(input logic op, input logic [BASE_CODE_W-1:0] b0,
                            input logic [BASE_CODE_W-1:0] b1,
                            input logic [BASE_CODE_W-1:0] b2,
                            input logic [VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_first_base <= b0;
      req_second_base <= b1;
      req_third_base <= b2;
      req_entry_log_prob <= value;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOOKUP) begin
         lookups++;
         if (b0 >= ALPHABET_SIZE && b1 >= ALPHABET_SIZE && b2 >= ALPHABET_SIZE) begin
            open_lookups++;
         end
      end else if (b0 < ALPHABET_SIZE && b1 < ALPHABET_SIZE && b2 < ALPHABET_SIZE) begin
         table_writes++;
         written[(int'(b0) * ALPHABET_SIZE + int'(b1)) * ALPHABET_SIZE + int'(b2)] = 1'b1;
      end else begin
         dropped_writes++;
      end
   endtask

   // hold the request channel quiet until every lookup has answered
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      logic [BASE_CODE_W-1:0] code [3];
      int                     hole;
      int unsigned            done;

      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_WRITE;
      req_first_base = '0;
      req_second_base = '0;
      req_third_base = '0;
      req_entry_log_prob = '0;
      rsp_ready = 1'b0;
      req_idle_pct = 7;
      rsp_idle_pct = 49;
      quiet_cycles = 0;
      table_writes = 0;
      dropped_writes = 0;
      lookups = 0;
      open_lookups = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         written[i] = 1'b0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: a single stored entry comes back unchanged
      send_word(OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF);
      send_word(OP_LOOKUP, 0, 0, 0, $urandom);
      // one row with max, log-zero, smallest non-zero and zero: the result stays at the max
      send_word(OP_WRITE, 0, 0, 1, LOG_ZERO);
      send_word(OP_WRITE, 0, 0, 2, 32'h8000_0001);
      send_word(OP_WRITE, 0, 0, 3, 32'h0000_0000);
      send_word(OP_LOOKUP, 0, 0, ANY_BASE, $urandom);
      // writes naming a wildcard are dropped, the entry keeps its old value
      send_word(OP_WRITE, ANY_BASE, 0, 0, 32'h1234_5678);
      send_word(OP_WRITE, 0, ANY_BASE_TOP, 0, 32'h0000_0000);
      send_word(OP_LOOKUP, 0, 0, 0, $urandom);
      // a code above the wildcard also matches every base
      send_word(OP_LOOKUP, 0, 0, ANY_BASE_TOP, $urandom);
      // every match log-zero gives log-zero
      for (int c = 0; c < ALPHABET_SIZE; c++) begin
         send_word(OP_WRITE, 1, 1, BASE_CODE_W'(c), LOG_ZERO);
      end
      send_word(OP_LOOKUP, 1, 1, ANY_BASE + 3'd1, $urandom);
      // equal values, a gap of exactly 16.0 and one just under it
      send_word(OP_WRITE, 2, 2, 0, 32'h0000_0000);
      send_word(OP_WRITE, 2, 2, 1, 32'h0000_0000);
      send_word(OP_WRITE, 2, 2, 2, 32'hFFF0_0000);
      send_word(OP_WRITE, 2, 2, 3, 32'hFFF0_0001);
      send_word(OP_LOOKUP, 2, 2, ANY_BASE, $urandom);
      wait_drained();

      // random phases: slow receiver, then slow sender, then full rate
      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 49 : 0;
         rsp_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 7 : 0;
         done = 0;
         while (done < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 35) begin
               for (int i = 0; i < 3; i++) begin
                  code[i] = BASE_CODE_W'($urandom_range(0, ALPHABET_SIZE - 1));
               end
               // now and then a wildcard write, which the block drops
               if ($urandom_range(0, 19) == 0) begin
                  code[$urandom_range(0, 2)] = BASE_CODE_W'($urandom_range(ALPHABET_SIZE, 7));
               end
               send_word(OP_WRITE, code[0], code[1], code[2], pick_log_prob());
               if (code[0] < ALPHABET_SIZE && code[1] < ALPHABET_SIZE
                   && code[2] < ALPHABET_SIZE) begin
                  done++;
               end
            end else begin
               for (int i = 0; i < 3; i++) begin
                  code[i] = ($urandom_range(0, 99) < 30)
                            ? BASE_CODE_W'($urandom_range(ALPHABET_SIZE, 7))
                            : BASE_CODE_W'($urandom_range(0, ALPHABET_SIZE - 1));
               end
               // a lookup over a hole turns into a write that fills it
               if (covered(code, hole)) begin
                  send_word(OP_LOOKUP, code[0], code[1], code[2], $urandom);
               end else begin
                  send_word(OP_WRITE, BASE_CODE_W'(hole / (ALPHABET_SIZE * ALPHABET_SIZE)),
                            BASE_CODE_W'((hole / ALPHABET_SIZE) % ALPHABET_SIZE),
                            BASE_CODE_W'(hole % ALPHABET_SIZE), pick_log_prob());
               end
               done++;
            end
         end
         // sender holds off until every lookup of the phase has answered
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("run: %0d table writes, %0d dropped wildcard writes, %0d lookups",
               table_writes, dropped_writes, lookups);
      $display("     %0d lookups with all three bases open, three idle patterns",
               open_lookups);
      if (fails == 0) begin
         $display("** codon_log_prob_marginalizer: PASSED **");
      end else begin
         $display("%0d mismatches", fails);
         $display("** codon_log_prob_marginalizer: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/clpm_pkg.sv
src/clpm_seq.sv
src/clpm_datapath.sv
src/codon_log_prob_marginalizer.sv
tb/sv/codon_sum_checker.sv
tb/sv/tb_codon_log_prob_marginalizer.sv
